### src/page_frame_fifo_lru_replacer_macros.svh
// ---------------------------------------------------------------------------
// Page frame replacer assertion macros
// Shared property wrappers for the replacer's internal checks.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_FIFO_LRU_REPLACER_MACROS_SVH
`define PAGE_FRAME_FIFO_LRU_REPLACER_MACROS_SVH

// same-cycle implication
`define PFR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfr: assertion failed");

// next-cycle implication
`define PFR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfr: assertion failed");

`endif

### src/pfr_pkg.sv
// ---------------------------------------------------------------------------
// Page frame replacer package
// Field widths, configuration codes and parameter defaults.
// ---------------------------------------------------------------------------
package pfr_pkg;

  localparam int PROC_W     = 2;
  localparam int VADDR_W    = 32;
  localparam int FRAME_W    = 6;
  localparam int PADDR_W    = 18;
  localparam int EVPAGE_W   = 20;

  localparam int DEF_NUM_FRAMES = 64;
  localparam int DEF_PAGE_BITS  = 12;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_REPLACE_MODE = '0;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

endpackage

### src/pfr_if.sv
// ---------------------------------------------------------------------------
// Page frame replacer channels
// Valid/ready channels for access items and result items.
// ---------------------------------------------------------------------------
interface pfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfr_pkg::PROC_W-1:0]  proc_id;
  logic [pfr_pkg::VADDR_W-1:0] virt_addr;

  modport source (output valid, output proc_id, output virt_addr, input ready);
  modport sink   (input valid, input proc_id, input virt_addr, output ready);
endinterface

interface pfr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [pfr_pkg::FRAME_W-1:0]  frame;
  logic [pfr_pkg::PADDR_W-1:0]  phys_addr;
  logic                         evicted_valid;
  logic [pfr_pkg::PROC_W-1:0]   evicted_proc;
  logic [pfr_pkg::EVPAGE_W-1:0] evicted_page;

  modport source (output valid, output hit, output frame, output phys_addr,
                  output evicted_valid, output evicted_proc, output evicted_page,
                  input ready);
  modport sink   (input valid, input hit, input frame, input phys_addr,
                  input evicted_valid, input evicted_proc, input evicted_page,
                  output ready);
endinterface

### src/pfr_apb_regs.sv
// ---------------------------------------------------------------------------
// Page frame replacer register block
// APB-style write/read access to the replacement mode register.
// ---------------------------------------------------------------------------
module pfr_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           replace_mode
);

  logic [pfr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[pfr_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode <= pfr_pkg::MODE_FIFO;
    end else if (wr_en && reg_idx == pfr_pkg::REG_REPLACE_MODE) begin
      replace_mode <= pwdata[0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      pfr_pkg::REG_REPLACE_MODE: prdata = {{(pfr_pkg::CFG_DATA_W-1){1'b0}}, replace_mode};
      default:                   prdata = '0;
    endcase
  end

endmodule

### src/page_frame_fifo_lru_replacer.sv
// ---------------------------------------------------------------------------
// Page frame replacer (FIFO / LRU)
// Looks up (process, page) among resident frames, loads faults into free
// frames or evicts the head of the replacement order list.
// ---------------------------------------------------------------------------
// Each item scans the frames resident (filled, at most NUM_FRAMES); a miss
// into a free frame then appends it, an LRU move or an eviction first reads
// and unlinks the list links. One item is taken at a time, only in idle; tags
// are scanned one frame per cycle through the single read port of the tag memory.
// Reset clears mode, fill count, list head/tail and handshake state; memories
// are not cleared, the fill count marks which frames hold pages.
module page_frame_fifo_lru_replacer #(
  parameter int NUM_FRAMES = pfr_pkg::DEF_NUM_FRAMES,
  parameter int PAGE_BITS  = pfr_pkg::DEF_PAGE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  pfr_in_if.sink                         in_ch,
  pfr_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  `include "page_frame_fifo_lru_replacer_macros.svh"

  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);
  localparam int PG_W  = pfr_pkg::VADDR_W - PAGE_BITS;
  localparam int TAG_W = pfr_pkg::PROC_W + PG_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_RDLINK = 3'd2;
  localparam logic [2:0] ST_UNLINK = 3'd3;
  localparam logic [2:0] ST_APPEND = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic       mode;

  // request
  logic [pfr_pkg::PROC_W-1:0] req_pid;
  logic [PG_W-1:0]            req_page;
  logic [PAGE_BITS-1:0]       req_off;

  // scan and sequencing
  logic [CNT_W-1:0] scan_idx;
  logic             rd_pending;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] f;
  logic             is_hit;
  logic             is_evict;
  logic [CNT_W-1:0] filled;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [pfr_pkg::PROC_W-1:0] ev_proc;
  logic [PG_W-1:0]            ev_page;

  // result register
  logic                          out_valid;
  logic                          out_hit;
  logic [pfr_pkg::FRAME_W-1:0]   out_frame;
  logic [pfr_pkg::PADDR_W-1:0]   out_phys;
  logic                          out_ev_valid;
  logic [pfr_pkg::PROC_W-1:0]    out_ev_proc;
  logic [pfr_pkg::EVPAGE_W-1:0]  out_ev_page;

  // memories
  logic [TAG_W-1:0] tag_mem  [NUM_FRAMES];
  logic [IDX_W-1:0] next_mem [NUM_FRAMES];
  logic [IDX_W-1:0] prev_mem [NUM_FRAMES];
  logic [TAG_W-1:0] tag_q;
  logic [IDX_W-1:0] next_q;
  logic [IDX_W-1:0] prev_q;

  logic [IDX_W-1:0] tag_raddr;
  logic             tag_we;
  logic             next_we;
  logic [IDX_W-1:0] next_waddr;
  logic [IDX_W-1:0] next_wdata;
  logic             prev_we;
  logic [IDX_W-1:0] prev_waddr;
  logic [IDX_W-1:0] prev_wdata;

  logic fill_new;
  logic link_tail;

  pfr_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .replace_mode (mode)
  );

  assign fill_new  = !is_hit && !is_evict;
  // a first load into an empty list sets head and tail instead of linking
  assign link_tail = !(fill_new && filled == '0);

  assign tag_raddr = (state == ST_SCAN) ? scan_idx[IDX_W-1:0] : f;
  assign tag_we    = (state == ST_UNLINK && is_evict) || (state == ST_APPEND && fill_new);

  always_comb begin
    next_we    = 1'b0;
    next_waddr = tail;
    next_wdata = f;
    prev_we    = 1'b0;
    prev_waddr = f;
    prev_wdata = tail;
    if (state == ST_UNLINK && is_hit) begin
      next_we    = (f != head);
      next_waddr = prev_q;
      next_wdata = next_q;
      prev_we    = 1'b1;
      prev_waddr = next_q;
      prev_wdata = prev_q;
    end else if (state == ST_APPEND) begin
      next_we = link_tail;
      prev_we = link_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[f] <= {req_pid, req_page};
    end
    tag_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_q <= next_mem[f];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_q <= prev_mem[f];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      filled     <= '0;
      head       <= '0;
      tail       <= '0;
      rd_pending <= 1'b0;
    end else begin
      // the done state refills the result register itself
      if (out_valid && out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            req_pid    <= in_ch.proc_id;
            req_page   <= in_ch.virt_addr[pfr_pkg::VADDR_W-1:PAGE_BITS];
            req_off    <= in_ch.virt_addr[PAGE_BITS-1:0];
            scan_idx   <= '0;
            rd_pending <= 1'b0;
            ev_proc    <= '0;
            ev_page    <= '0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_pending && tag_q == {req_pid, req_page}) begin
            f          <= rd_idx;
            is_hit     <= 1'b1;
            is_evict   <= 1'b0;
            rd_pending <= 1'b0;
            if (mode == pfr_pkg::MODE_LRU && rd_idx != tail && filled > CNT_W'(1)) begin
              state <= ST_RDLINK;
            end else begin
              state <= ST_DONE;
            end
          end else if (scan_idx < filled) begin
            rd_pending <= 1'b1;
            rd_idx     <= scan_idx[IDX_W-1:0];
            scan_idx   <= scan_idx + 1'b1;
          end else begin
            rd_pending <= 1'b0;
            is_hit     <= 1'b0;
            if (filled < CNT_W'(NUM_FRAMES)) begin
              f        <= filled[IDX_W-1:0];
              is_evict <= 1'b0;
              state    <= ST_APPEND;
            end else begin
              f        <= head;
              is_evict <= 1'b1;
              state    <= ST_RDLINK;
            end
          end
        end
        ST_RDLINK: begin
          state <= ST_UNLINK;
        end
        ST_UNLINK: begin
          if (is_evict) begin
            ev_proc <= tag_q[TAG_W-1 -: pfr_pkg::PROC_W];
            ev_page <= tag_q[PG_W-1:0];
            if (filled > CNT_W'(1)) begin
              head  <= next_q;
              state <= ST_APPEND;
            end else begin
              state <= ST_DONE;
            end
          end else begin
            if (f == head) begin
              head <= next_q;
            end
            state <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          if (!link_tail) begin
            head <= f;
          end
          tail <= f;
          if (fill_new) begin
            filled <= filled + 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid    <= 1'b1;
            out_hit      <= is_hit;
            out_frame    <= pfr_pkg::FRAME_W'(f);
            out_phys     <= pfr_pkg::PADDR_W'({f, req_off});
            out_ev_valid <= is_evict;
            out_ev_proc  <= ev_proc;
            out_ev_page  <= pfr_pkg::EVPAGE_W'(ev_page);
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready          = (state == ST_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.hit           = out_hit;
  assign out_ch.frame         = out_frame;
  assign out_ch.phys_addr     = out_phys;
  assign out_ch.evicted_valid = out_ev_valid;
  assign out_ch.evicted_proc  = out_ev_proc;
  assign out_ch.evicted_page  = out_ev_page;

  `PFR_ASSERT_IMP(a_filled_max, clk, rst, 1'b1, filled <= CNT_W'(NUM_FRAMES))
  `PFR_ASSERT_IMP(a_evict_full, clk, rst, out_valid && out_ev_valid, filled == CNT_W'(NUM_FRAMES))
  `PFR_ASSERT_IMP(a_hit_resident, clk, rst, state == ST_DONE && is_hit, CNT_W'(f) < filled)
  `PFR_ASSERT_IMP(a_scan_bound, clk, rst, state == ST_SCAN, scan_idx <= filled)
  `PFR_ASSERT_NEXT(a_fill_step, clk, rst, state == ST_APPEND && fill_new, filled == CNT_W'($past(filled) + 1'b1))

endmodule
